### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cstrip_pkg.sv
// ----------------------------------------------------------------------------
// cstrip_pkg
// characters and shared types of the comment stripper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cstrip_pkg;

   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // words produced by one input word, data0 goes out first
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data0;
      logic [7:0] data1;
   } cstrip_res_type;

endpackage

`default_nettype wire

### rtl/core/comment_stripper.sv
// datapath: a word accepted into the input stage is scanned and pushed into the
//   result queue, whose head slot drives rsp
// throughput: one input word per cycle while the result queue has room; a word
//   yielding two results sends them out one after the other, and the four-slot
//   result queue absorbs that and stalls input while fewer than two slots are free
// reset: synchronous, active high; clears scanner state, input stage and queue
// ----------------------------------------------------------------------------
// comment_stripper
// streaming removal of line and block comments, string aware
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module comment_stripper (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast    // last_of_run
);
   import cstrip_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           room;
   logic           fire;
   cstrip_res_type res;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   cstrip_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .res     (res)
   );

   cstrip_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .res        (res),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### rtl/core/cstrip_scan.sv
// ----------------------------------------------------------------------------
// cstrip_scan
// scanner state machine: decides which bytes of one input word are kept
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cstrip_scan (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire logic [7:0]                in_char,
   input  wire logic                      in_last,
   output cstrip_pkg::cstrip_res_type     res
);
   import cstrip_pkg::*;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_STRING = 3'd1,
      MODE_ESC    = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_BLOCK  = 3'd4
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     held_ff, held_in;
   logic     star_ff, star_in;

   logic emit_pre;   // held slash released ahead of the byte
   logic emit_chr;   // the byte itself
   logic emit_tail;  // held slash flushed at end of text

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      star_in   = star_ff;
      emit_pre  = 1'b0;
      emit_chr  = 1'b0;
      emit_tail = 1'b0;
      case (mode_ff)
         MODE_STRING: begin
            emit_chr = 1'b1;
            if (in_char == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else if (in_char == CH_QUOTE) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_ESC: begin
            emit_chr = 1'b1;
            mode_in  = MODE_STRING;
         end
         MODE_LINE: begin
            if (in_char == CH_NEWLINE) begin
               emit_chr = 1'b1;
               mode_in  = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && in_char == CH_SLASH) begin
               mode_in = MODE_NORMAL;
               star_in = 1'b0;
            end else begin
               star_in = (in_char == CH_STAR);
            end
         end
         default: begin
            // normal text, unused codes land here too
            mode_in = MODE_NORMAL;
            if (held_ff && in_char == CH_SLASH) begin
               held_in = 1'b0;
               mode_in = MODE_LINE;
            end else if (held_ff && in_char == CH_STAR) begin
               held_in = 1'b0;
               mode_in = MODE_BLOCK;
               star_in = 1'b0;
            end else begin
               emit_pre = held_ff;
               held_in  = 1'b0;
               if (in_char == CH_QUOTE) begin
                  emit_chr = 1'b1;
                  mode_in  = MODE_STRING;
               end else if (in_char == CH_SLASH) begin
                  held_in = 1'b1;
               end else begin
                  emit_chr = 1'b1;
               end
            end
         end
      endcase
      if (in_last) begin
         emit_tail = held_in;
         mode_in   = MODE_NORMAL;
         held_in   = 1'b0;
         star_in   = 1'b0;
      end
   end

   // a released slash and a flushed slash never come together
   always_comb begin
      res.count = {1'b0, emit_pre} + {1'b0, emit_chr} + {1'b0, emit_tail};
      res.data0 = emit_pre ? CH_SLASH : (emit_chr ? in_char : CH_SLASH);
      res.data1 = (emit_pre && emit_chr) ? in_char : CH_SLASH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         held_ff <= 1'b0;
         star_ff <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         star_ff <= star_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cstrip_outq.sv
// ----------------------------------------------------------------------------
// cstrip_outq
// four-slot shifting result queue, takes up to two words per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cstrip_outq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  cstrip_pkg::cstrip_res_type     res,
   output logic                           room,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast    // last_of_run
);
   import cstrip_pkg::*;

   localparam int Depth = 4;

   logic [8:0] slot_ff [Depth];
   logic [8:0] slot_in [Depth];
   logic [2:0] fill_ff, fill_in;
   logic [2:0] base;
   logic       pop;
   logic [8:0] word0, word1;

   assign rsp_tvalid = (fill_ff != 3'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   // room for two words regardless of what leaves this cycle
   assign room       = (fill_ff <= 3'd2);
   assign rsp_tdata  = slot_ff[0][8:1];
   assign rsp_tlast  = slot_ff[0][0];

   assign base  = fill_ff - {2'b00, pop};
   assign word0 = {res.data0, (res.count == 2'd1)};
   assign word1 = {res.data1, 1'b1};

   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         if (pop && i < Depth - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push && res.count != 2'd0 && base == 3'(i)) begin
            slot_in[i] = word0;
         end
         if (push && res.count == 2'd2 && base + 3'd1 == 3'(i)) begin
            slot_in[i] = word1;
         end
      end
      fill_in = push ? base + {1'b0, res.count} : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Depth; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

`default_nettype wire

### rtl/core/comment_stripper_chk.sv
// ----------------------------------------------------------------------------
// comment_stripper_chk
// port-level checks on the comment stripper, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module comment_stripper_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // nothing comes out right after reset
   `ASSERT_CLK_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")

   // input side opens right after reset
   `ASSERT_CLK_ALWAYS(a_req_ready_after_reset, clock, reset |=> req_tready, "req_tready low after reset")

   // stalled result word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

   // second word of a pair is already queued when the first leaves
   `ASSERT_CLK(a_pair_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "no word after non-last word")

   // input only backs up while results are waiting
   `ASSERT_CLK(a_stall_needs_output, clock, reset, !req_tready |-> rsp_tvalid, "input stalled with empty output")

endmodule

bind comment_stripper comment_stripper_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
